/* sv/psch_pkg.sv */
// Shared types and result codes of the periodic task scheduler.
package psch_pkg;

    // Result kinds carried on the master-side tuser
    typedef enum logic [1:0] {
        KIND_ADD_OK   = 2'd0,
        KIND_ADD_FULL = 2'd1,
        KIND_FIRED    = 2'd2,
        KIND_SUMMARY  = 2'd3
    } kind_t;

    // Input selector carried on the slave-side tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;

    localparam int          TIME_W    = 64;
    localparam int          PERIOD_W  = 32;
    localparam int          OUT_IDX_W = 3;
    localparam logic [63:0] NO_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFF;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic tick_start;  // advance time, clear scan index, set running minimum to all ones
        logic add_start;   // latch the period of an add transaction
        logic add_exec;    // store the new task or report full, emit result
        logic rd;          // read the table entry at the scan index
        logic eval;        // compare deadline with time and form next deadline
        logic commit;      // write back, fold into minimum, emit fired result
        logic sum_emit;    // emit the closing summary
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic count_zero;  // no task in the table
        logic last_entry;  // scan index is the last filled entry
        logic due;         // evaluated entry has fired
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

/* sv/periodic_task_scheduler_core.sv */
// Top level of the periodic task scheduler: controller and datapath.
//
// Keeps a table of up to MAX_TASKS periodic tasks and a 64-bit millisecond
// counter. An add transaction (s_tuser = 1, period in s_tdata) stores a task
// due at now + period and returns one result with its index, or a full
// report. A tick transaction (s_tuser = 0) advances time by one, scans the
// filled entries in index order, returns one fired result for each due task
// (its deadline moves on by one period), then a summary with the soonest
// deadline, all ones when the table is empty. Results carry tlast on the
// final one of each transaction. A tick handles each stored task in read,
// evaluate and commit steps around the table memory's registered read
// port. A waiting result sits in an output register, so a new transaction
// is taken while it waits.
module periodic_task_scheduler_core
    import psch_pkg::*;
#(
    parameter int MAX_TASKS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] period
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] task_index, [66:3] soonest, [71:67] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    cmd_t    cmd;
    status_t status;

    psch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_func   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psch_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* sv/psch_ctrl.sv */
// Sequencer of the periodic task scheduler: handshake and per-entry scan steps.
module psch_ctrl
    import psch_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_func,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_ADD     = 6'b000010,
        ST_READ    = 6'b000100,
        ST_EVAL    = 6'b001000,
        ST_COMMIT  = 6'b010000,
        ST_SUMMARY = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_func == FUNC_ADD)
                    begin
                        cmd.add_start = 1'b1;
                        state_next    = ST_ADD;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = status.count_zero ? ST_SUMMARY : ST_READ;
                    end
                end
            end
            ST_ADD:
            begin
                if (status.out_free)
                begin
                    cmd.add_exec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold while a fired result has nowhere to go
                if (!status.due || status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = status.last_entry ? ST_SUMMARY : ST_READ;
                end
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    cmd.sum_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/psch_datapath.sv */
// Datapath of the periodic task scheduler: task table, time counter, result register.
module psch_datapath
    import psch_pkg::*;
#(
    parameter int MAX_TASKS = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   s_tdata,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [71:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast,
    input  cmd_t          cmd,
    output status_t       status
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    // Task table
    logic [TIME_W-1:0]   dl_mem [MAX_TASKS];
    logic [PERIOD_W-1:0] pd_mem [MAX_TASKS];

    logic [TIME_W-1:0]   time_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TIME_W-1:0]   rd_dl_reg;
    logic [PERIOD_W-1:0] rd_pd_reg;
    logic [TIME_W-1:0]   upd_reg;
    logic                due_reg;
    logic [TIME_W-1:0]   soon_reg;

    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [TIME_W-1:0]   out_soon_reg;
    logic                out_last_reg;

    logic                full;
    logic [IDX_W-1:0]    add_addr;
    logic [TIME_W-1:0]   commit_dl;

    logic                dl_we;
    logic [IDX_W-1:0]    dl_waddr;
    logic [TIME_W-1:0]   dl_wdata;
    logic                pd_we;

    logic                 emit;
    kind_t                emit_kind;
    logic [OUT_IDX_W-1:0] emit_idx;
    logic [TIME_W-1:0]    emit_soon;
    logic                 emit_last;

    assign full      = (count_reg == CNT_W'(MAX_TASKS));
    assign add_addr  = count_reg[IDX_W-1:0];
    assign commit_dl = due_reg ? upd_reg : rd_dl_reg;

    // Status toward the controller
    assign status.count_zero = (count_reg == '0);
    assign status.last_entry = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign status.due        = due_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    // Table write port select
    always_comb
    begin
        dl_we    = 1'b0;
        dl_waddr = idx_reg;
        dl_wdata = upd_reg;
        pd_we    = 1'b0;
        if (cmd.add_exec && !full)
        begin
            dl_we    = 1'b1;
            dl_waddr = add_addr;
            dl_wdata = time_reg + TIME_W'(period_reg);
            pd_we    = 1'b1;
        end
        else if (cmd.commit && due_reg)
        begin
            dl_we = 1'b1;
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[dl_waddr] <= dl_wdata;
        end
        if (pd_we)
        begin
            pd_mem[add_addr] <= period_reg;
        end
        if (cmd.rd)
        begin
            rd_dl_reg <= dl_mem[idx_reg];
            rd_pd_reg <= pd_mem[idx_reg];
        end
    end

    // Control state: time counter and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.tick_start)
            begin
                time_reg <= time_reg + TIME_W'(1);
            end
            if (cmd.add_exec && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Scan datapath: period latch, index, due check, next deadline, running minimum
    always_ff @(posedge clk)
    begin
        if (cmd.add_start)
        begin
            period_reg <= s_tdata;
        end
        if (cmd.tick_start)
        begin
            idx_reg  <= '0;
            soon_reg <= NO_DEADLINE;
        end
        if (cmd.eval)
        begin
            due_reg <= (time_reg >= rd_dl_reg);
            upd_reg <= rd_dl_reg + TIME_W'(rd_pd_reg);
        end
        if (cmd.commit)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (commit_dl < soon_reg)
            begin
                soon_reg <= commit_dl;
            end
        end
    end

    // Result selection
    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_SUMMARY;
        emit_idx  = '0;
        emit_soon = '0;
        emit_last = 1'b1;
        if (cmd.add_exec)
        begin
            emit      = 1'b1;
            emit_kind = full ? KIND_ADD_FULL : KIND_ADD_OK;
            emit_idx  = full ? '0 : OUT_IDX_W'(add_addr);
        end
        else if (cmd.commit && due_reg)
        begin
            emit      = 1'b1;
            emit_kind = KIND_FIRED;
            emit_idx  = OUT_IDX_W'(idx_reg);
            emit_last = 1'b0;
        end
        else if (cmd.sum_emit)
        begin
            emit      = 1'b1;
            emit_soon = soon_reg;
        end
    end

    // Output register: hold until taken, load on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= emit_kind;
            out_idx_reg  <= emit_idx;
            out_soon_reg <= emit_soon;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_soon_reg, out_idx_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* sv/psch_checker.sv */
// Port-level checks of the periodic task scheduler, bound to the top level.
module psch_checker
    import psch_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Fired results never close a transaction and carry no deadline
    a_fired_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_FIRED |-> !m_tlast && m_tdata[66:3] == '0)
        else $error("fired result malformed");

    // Add results close their transaction and carry no deadline
    a_add_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ADD_OK || m_tuser == KIND_ADD_FULL)
            |-> m_tlast && m_tdata[66:3] == '0)
        else $error("add result malformed");

    // Summary closes a tick and carries index zero
    a_sum_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast && m_tdata[2:0] == '0)
        else $error("summary result malformed");

endmodule

bind periodic_task_scheduler_core psch_checker u_psch_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
